>>> design/vdib_pkg.sv
// Package for the vertex deduplication index builder.
// Holds the input and result word types, field widths, register codes and the
// sequencer state type. Depends on nothing.
package vdib_pkg;

  localparam int WORD_W = 32;  // width of one weight word on the ports
  localparam int VIDX_W = 10;
  localparam int REF_W  = 12;
  localparam int ELEM_W = 12;
  localparam int WPV_W  = 3;

  localparam logic [WPV_W-1:0] WPV_THREE = 3'd3;
  localparam logic [WPV_W-1:0] WPV_FOUR  = 3'd4;

  localparam logic MODE_BASE    = 1'b0;
  localparam logic MODE_DERIVED = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] weight0;
    logic [WORD_W-1:0] weight1;
    logic [WORD_W-1:0] weight2;
    logic [WORD_W-1:0] weight3;
    logic              last_corner;
  } in_word_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              is_new;
    logic [REF_W-1:0]  reference;
    logic [ELEM_W-1:0] element_number;
    logic              not_found;
    logic              table_full;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BSEARCH,
    ST_DONE
  } vdib_state_t;

endpackage

>>> design/vertex_dedup_index_builder.sv
// Top level of the vertex deduplication index builder: sequencer, counts,
// output register. Depends on vdib_pkg, vdib_ram and vdib_cmp.
//
//   channel | direction | ports                          | word
//   in      | input     | in_valid, in_ready, in_data    | vdib_pkg::in_word_t
//   out     | output    | out_valid, out_ready, out_data | vdib_pkg::out_word_t
//   cfg     | input     | cfg_valid, cfg_ready, cfg_data | weights per vertex
//
// A corner searches its own table, of V vertices; a derived corner that misses
// then searches the base table too, of B vertices. The single read port of each
// vertex store and the one shared comparator look at one stored vertex per cycle.
// Reset is synchronous; no clearing pass is needed, as searches read only
// entries below the counts. The input is taken only in the idle state; a result
// left waiting in the output register holds back the next result, and the input with it.
module vertex_dedup_index_builder #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_ELEMENTS = 4096,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vdib_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vdib_pkg::out_word_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vdib_pkg::WPV_W-1:0]        cfg_data
);

  localparam int SW  = (WEIGHT_BITS < vdib_pkg::WORD_W) ? WEIGHT_BITS : vdib_pkg::WORD_W;
  localparam int CW  = 4 * SW;
  localparam int RW  = vdib_pkg::REF_W;
  localparam int BW  = CW + RW;
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int ECW = $clog2(MAX_ELEMENTS + 1);
  localparam int XW  = vdib_pkg::VIDX_W;
  localparam int EW  = vdib_pkg::ELEM_W;

  vdib_pkg::vdib_state_t state_r, state_nxt;

  logic [vdib_pkg::WPV_W-1:0] wpv_r;
  logic              mode_r, mode_nxt;
  logic              last_r, last_nxt;
  logic              four_r, four_nxt;
  logic [CW-1:0]     corner_r, corner_nxt;
  logic [ECW-1:0]    elem_r, elem_nxt;
  logic [VCW-1:0]    issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic [VAW-1:0]    pidx_r, pidx_nxt;
  logic [VCW-1:0]    base_v_r, base_v_nxt;
  logic [ECW-1:0]    base_e_r, base_e_nxt;
  logic              restart_r, restart_nxt;
  logic [VCW-1:0]    der_v_r, der_v_nxt;
  logic [ECW-1:0]    der_e_r, der_e_nxt;
  vdib_pkg::out_word_t res_r, res_nxt;
  vdib_pkg::out_word_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              base_we;
  logic              der_we;
  logic [BW-1:0]     base_wdata;
  logic [BW-1:0]     base_rd;
  logic [CW-1:0]     der_rd;
  logic [CW-1:0]     cmp_stored;
  logic              match;

  logic [CW-1:0]     in_corner;
  logic              restart_now;
  logic [ECW-1:0]    elem_eff;
  logic [VCW-1:0]    search_cnt;
  logic              hit;
  logic [RW-1:0]     new_ref;

  assign in_corner = {in_data.weight3[SW-1:0], in_data.weight2[SW-1:0],
                      in_data.weight1[SW-1:0], in_data.weight0[SW-1:0]};

  assign in_ready  = (state_r == vdib_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  vdib_ram #(.WIDTH(BW), .DEPTH(MAX_VERTICES)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_v_r[VAW-1:0]),
    .wdata (base_wdata),
    .raddr (issue_r[VAW-1:0]),
    .rdata (base_rd)
  );

  vdib_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_der_ram (
    .clk   (clk),
    .we    (der_we),
    .waddr (der_v_r[VAW-1:0]),
    .wdata (corner_r),
    .raddr (issue_r[VAW-1:0]),
    .rdata (der_rd)
  );

  // Only the derived table's own search reads the derived store.
  assign cmp_stored = (state_r == vdib_pkg::ST_SEARCH && mode_r == vdib_pkg::MODE_DERIVED)
                      ? der_rd : base_rd[CW-1:0];

  vdib_cmp #(.SW(SW)) u_cmp (
    .corner     (corner_r),
    .stored     (cmp_stored),
    .four_words (four_r),
    .match      (match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdib_pkg::ST_IDLE;
      wpv_r       <= vdib_pkg::WPV_THREE;
      pend_r      <= 1'b0;
      base_v_r    <= '0;
      base_e_r    <= '0;
      restart_r   <= 1'b1;
      der_v_r     <= '0;
      der_e_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        wpv_r <= cfg_data;
      end
      pend_r      <= pend_nxt;
      base_v_r    <= base_v_nxt;
      base_e_r    <= base_e_nxt;
      restart_r   <= restart_nxt;
      der_v_r     <= der_v_nxt;
      der_e_r     <= der_e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    last_r   <= last_nxt;
    four_r   <= four_nxt;
    corner_r <= corner_nxt;
    elem_r   <= elem_nxt;
    issue_r  <= issue_nxt;
    pidx_r   <= pidx_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign restart_now = (in_data.mode == vdib_pkg::MODE_BASE) && restart_r;
  assign elem_eff    = restart_now ? '0
                     : (in_data.mode == vdib_pkg::MODE_DERIVED) ? der_e_r : base_e_r;
  assign search_cnt  = (state_r == vdib_pkg::ST_BSEARCH || mode_r == vdib_pkg::MODE_BASE)
                       ? base_v_r : der_v_r;
  assign hit         = pend_r && match;
  assign new_ref     = RW'(elem_r);
  assign base_wdata  = {new_ref, corner_r};

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    last_nxt      = last_r;
    four_nxt      = four_r;
    corner_nxt    = corner_r;
    elem_nxt      = elem_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    base_v_nxt    = base_v_r;
    base_e_nxt    = base_e_r;
    restart_nxt   = restart_r;
    der_v_nxt     = der_v_r;
    der_e_nxt     = der_e_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    base_we       = 1'b0;
    der_we        = 1'b0;

    case (state_r)
      vdib_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          last_nxt   = in_data.last_corner;
          four_nxt   = (wpv_r == vdib_pkg::WPV_FOUR);
          corner_nxt = in_corner;
          elem_nxt   = elem_eff;
          issue_nxt  = '0;
          res_nxt    = '0;
          res_nxt.element_number = EW'(elem_eff);
          if (restart_now) begin
            base_v_nxt  = '0;
            base_e_nxt  = '0;
            restart_nxt = 1'b0;
          end
          if (elem_eff >= ECW'(MAX_ELEMENTS)) begin
            res_nxt.table_full = 1'b1;
            state_nxt = vdib_pkg::ST_DONE;
          end else begin
            state_nxt = vdib_pkg::ST_SEARCH;
          end
        end
      end

      vdib_pkg::ST_SEARCH: begin
        if (hit) begin
          res_nxt.vertex_index = XW'(pidx_r);
          if (mode_r == vdib_pkg::MODE_DERIVED) begin
            der_e_nxt = der_e_r + ECW'(1);
          end else begin
            base_e_nxt = base_e_r + ECW'(1);
          end
          state_nxt = vdib_pkg::ST_DONE;
        end else if (issue_r < search_cnt) begin
          issue_nxt = issue_r + VCW'(1);
          pend_nxt  = 1'b1;
          pidx_nxt  = issue_r[VAW-1:0];
        end else if (search_cnt >= VCW'(MAX_VERTICES)) begin
          res_nxt.table_full = 1'b1;
          state_nxt = vdib_pkg::ST_DONE;
        end else if (mode_r == vdib_pkg::MODE_BASE) begin
          // A new base vertex takes its own element number as reference.
          base_we              = 1'b1;
          res_nxt.vertex_index = XW'(base_v_r);
          res_nxt.is_new       = 1'b1;
          res_nxt.reference    = new_ref;
          base_v_nxt           = base_v_r + VCW'(1);
          base_e_nxt           = base_e_r + ECW'(1);
          state_nxt            = vdib_pkg::ST_DONE;
        end else begin
          issue_nxt = '0;
          state_nxt = vdib_pkg::ST_BSEARCH;
        end
      end

      vdib_pkg::ST_BSEARCH: begin
        if (!hit && issue_r < search_cnt) begin
          issue_nxt = issue_r + VCW'(1);
          pend_nxt  = 1'b1;
          pidx_nxt  = issue_r[VAW-1:0];
        end else begin
          der_we               = 1'b1;
          res_nxt.vertex_index = XW'(der_v_r);
          res_nxt.is_new       = 1'b1;
          res_nxt.reference    = hit ? base_rd[CW +: RW] : '0;
          res_nxt.not_found    = !hit;
          der_v_nxt            = der_v_r + VCW'(1);
          der_e_nxt            = der_e_r + ECW'(1);
          state_nxt            = vdib_pkg::ST_DONE;
        end
      end

      vdib_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = vdib_pkg::ST_IDLE;
          // The base table is kept for derived searches until the next base word.
          if (last_r) begin
            if (mode_r == vdib_pkg::MODE_DERIVED) begin
              der_v_nxt = '0;
              der_e_nxt = '0;
            end else begin
              restart_nxt = 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = vdib_pkg::ST_IDLE;
      end
    endcase
  end

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (base_v_r <= VCW'(MAX_VERTICES)) && (der_v_r <= VCW'(MAX_VERTICES)))
    else $error("vertex count beyond store depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != vdib_pkg::ST_IDLE))
    else $error("accepted word did not start a search");

  a_base_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    base_we |-> (mode_r == vdib_pkg::MODE_BASE && state_r == vdib_pkg::ST_SEARCH))
    else $error("base store written outside a base search");

  a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.table_full) |-> (!out_r.is_new && !out_r.not_found))
    else $error("full result marked as new vertex");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vdib_pkg::ST_DONE && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished result not presented");

endmodule

>>> design/vdib_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the vertex stores. Depends on nothing.
module vdib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/vdib_cmp.sv
// Shared corner comparator: compares a held corner against one stored vertex.
// Three or four weight words take part. Depends on nothing.
module vdib_cmp #(
  parameter int SW = 32
) (
  input  logic [4*SW-1:0] corner,
  input  logic [4*SW-1:0] stored,
  input  logic            four_words,
  output logic            match
);

  logic low_eq;
  logic top_eq;

  assign low_eq = (corner[3*SW-1:0] == stored[3*SW-1:0]);
  assign top_eq = (corner[4*SW-1:3*SW] == stored[4*SW-1:3*SW]);
  assign match  = low_eq && (top_eq || !four_words);

endmodule

>>> tb/sv/vertex_dedup_index_builder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertex_dedup_index_builder: directed and random corners,
// checked word by word against an in-bench model of the base and derived vertex tables.
// Depends on vdib_pkg and the vertex_dedup_index_builder RTL.
module vertex_dedup_index_builder_test;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_ELEMENTS = 4096;
  localparam int STALL_LIMIT  = 10000;
  localparam int HOLD_CYCLES  = 300;

  // Register settings other than four, all of which compare three words.
  localparam logic [vdib_pkg::WPV_W-1:0] WPV_ODD_LOW  = 3'd0;
  localparam logic [vdib_pkg::WPV_W-1:0] WPV_ODD_MID  = 3'd6;
  localparam logic [vdib_pkg::WPV_W-1:0] WPV_ODD_HIGH = 3'd7;

  typedef logic [3:0][vdib_pkg::WORD_W-1:0] corner_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  vdib_pkg::in_word_t         in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  vdib_pkg::out_word_t        out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [vdib_pkg::WPV_W-1:0] cfg_data = '0;

  // Model of the two vertex tables and the register.
  corner_t                    base_corners [MAX_VERTICES];
  logic [vdib_pkg::REF_W-1:0] base_refs [MAX_VERTICES];
  corner_t                    derived_corners [MAX_VERTICES];
  int                         base_vcount = 0;
  int                         base_ecount = 0;
  bit                         base_reopen = 1'b1;
  int                         derived_vcount = 0;
  int                         derived_ecount = 0;
  logic [vdib_pkg::WPV_W-1:0] weights_cfg = vdib_pkg::WPV_THREE;

  vdib_pkg::out_word_t        expected_entries [$];
  int                         errors = 0;
  int                         send_idle_pct = 0;
  int                         recv_idle_pct = 0;
  bit                         hold_request = 1'b0;
  bit                         hold_taken = 1'b0;
  int                         hold_left = 0;
  int                         quiet_cycles = 0;

  vertex_dedup_index_builder #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int find_vertex(input bit in_derived, input int count, input corner_t c,
                                     input int n);
    bit same;
    for (int i = 0; i < count && i < MAX_VERTICES; i++) begin
      same = 1'b1;
      for (int k = 0; k < n; k++) begin
        if ((in_derived ? derived_corners[i][k] : base_corners[i][k]) != c[k]) same = 1'b0;
      end
      if (same) return i;
    end
    return -1;
  endfunction

  // Works out the result word for one corner and updates the table model.
  function automatic vdib_pkg::out_word_t index_corner(input vdib_pkg::in_word_t w);
    vdib_pkg::out_word_t r;
    corner_t   c;
    bit        derived;
    int        n;
    int        elem;
    int        vcount;
    int        hit;
    int        b;
    c = {w.weight3, w.weight2, w.weight1, w.weight0};
    n = (weights_cfg == vdib_pkg::WPV_FOUR) ? 4 : 3;
    derived = (w.mode == vdib_pkg::MODE_DERIVED);
    r = '0;
    if (!derived && base_reopen) begin
      base_vcount = 0;
      base_ecount = 0;
      base_reopen = 1'b0;
    end
    elem = derived ? derived_ecount : base_ecount;
    vcount = derived ? derived_vcount : base_vcount;
    r.element_number = vdib_pkg::ELEM_W'(elem);
    if (elem >= MAX_ELEMENTS) begin
      r.table_full = 1'b1;
    end else begin
      hit = find_vertex(derived, vcount, c, n);
      if (hit >= 0) begin
        r.vertex_index = vdib_pkg::VIDX_W'(hit);
        if (derived) derived_ecount++;
        else base_ecount++;
      end else if (vcount >= MAX_VERTICES) begin
        r.table_full = 1'b1;
      end else begin
        if (!derived) begin
          r.reference = vdib_pkg::REF_W'(elem);
          base_corners[vcount] = c;
          base_refs[vcount] = vdib_pkg::REF_W'(elem);
          base_vcount++;
          base_ecount++;
        end else begin
          // A derived vertex takes its reference from the base table, if it is there.
          b = find_vertex(1'b0, base_vcount, c, n);
          if (b >= 0) r.reference = base_refs[b];
          else r.not_found = 1'b1;
          derived_corners[vcount] = c;
          derived_vcount++;
          derived_ecount++;
        end
        r.vertex_index = vdib_pkg::VIDX_W'(vcount);
        r.is_new = 1'b1;
      end
    end
    if (w.last_corner) begin
      if (derived) begin
        derived_vcount = 0;
        derived_ecount = 0;
      end else begin
        base_reopen = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic vdib_pkg::in_word_t make_word(input logic derived, input corner_t c,
                                                   input logic closes);
    vdib_pkg::in_word_t w;
    w.mode = derived ? vdib_pkg::MODE_DERIVED : vdib_pkg::MODE_BASE;
    w.weight0 = c[0];
    w.weight1 = c[1];
    w.weight2 = c[2];
    w.weight3 = c[3];
    w.last_corner = closes;
    return w;
  endfunction

  function automatic logic [vdib_pkg::WORD_W-1:0] random_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic corner_t random_corner();
    corner_t c;
    for (int k = 0; k < 4; k++) c[k] = random_weight();
    return c;
  endfunction

  // Receiver: random stalls, or a long hold-off once one is requested.
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    vdib_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = expected_entries.pop_front();
        check_field("vertex_index", want.vertex_index, out_data.vertex_index);
        check_field("is_new", want.is_new, out_data.is_new);
        check_field("reference", want.reference, out_data.reference);
        check_field("element_number", want.element_number, out_data.element_number);
        check_field("not_found", want.not_found, out_data.not_found);
        check_field("table_full", want.table_full, out_data.table_full);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("vertex_dedup_index_builder_test: FAIL");
        $finish;
      end
    end
  end

  // Called and returns at a falling edge; valid is left high for the next word.
  task automatic send_corner(input vdib_pkg::in_word_t word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_entries.push_back(index_corner(word));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_entries.size() != 0) @(negedge clk);
  endtask

  task automatic set_weights_per_vertex(input logic [vdib_pkg::WPV_W-1:0] value);
    wait_for_results();
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    weights_cfg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_corner_basics();
    corner_t zeros;
    corner_t ones;
    corner_t mixed;
    zeros = '0;
    ones = '1;
    mixed = {32'h0000_0001, 32'h8000_0000, 32'h1234_5678, 32'hDEAD_BEEF};
    send_corner(make_word(1'b0, zeros, 1'b0));
    send_corner(make_word(1'b0, ones, 1'b0));
    send_corner(make_word(1'b0, zeros, 1'b0));
    // Differs only in the fourth word, so it still hits with three compared.
    send_corner(make_word(1'b0, {32'hFFFF_FFFF, 96'h0}, 1'b0));
    send_corner(make_word(1'b0, ones, 1'b1));
    send_corner(make_word(1'b1, zeros, 1'b0));
    send_corner(make_word(1'b1, ones, 1'b0));
    send_corner(make_word(1'b1, mixed, 1'b0));
    send_corner(make_word(1'b1, ones, 1'b0));
    send_corner(make_word(1'b1, mixed, 1'b1));
    // The derived table starts anew; then the next base word restarts the base table.
    send_corner(make_word(1'b1, mixed, 1'b0));
    send_corner(make_word(1'b0, mixed, 1'b0));
    send_corner(make_word(1'b0, zeros, 1'b1));
    wait_for_results();
  endtask

  task automatic test_weight_setting();
    corner_t a;
    corner_t b;
    a = {32'hCAFE_F00D, 32'h0F0F_0F0F, 32'h7FFF_FFFF, 32'h0000_8000};
    b = a;
    b[3] = ~a[3];
    set_weights_per_vertex(vdib_pkg::WPV_FOUR);
    send_corner(make_word(1'b0, a, 1'b0));
    send_corner(make_word(1'b0, b, 1'b0));
    send_corner(make_word(1'b0, a, 1'b0));
    send_corner(make_word(1'b0, b, 1'b1));
    send_corner(make_word(1'b1, b, 1'b0));
    set_weights_per_vertex(WPV_ODD_LOW);
    send_corner(make_word(1'b1, a, 1'b1));
    set_weights_per_vertex(WPV_ODD_HIGH);
    send_corner(make_word(1'b0, a, 1'b0));
    send_corner(make_word(1'b0, b, 1'b1));
    set_weights_per_vertex(vdib_pkg::WPV_THREE);
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    repeat (10) send_corner(make_word(1'($urandom_range(1)), random_corner(), 1'b0));
    wait_for_results();
  endtask

  // One table built from a small pool of corners, so that hits are common.
  task automatic send_table(input bit derived, input int length);
    corner_t pool [6];
    corner_t c;
    int      kinds;
    kinds = $urandom_range(1, 6);
    for (int i = 0; i < kinds; i++) begin
      if (derived && base_vcount > 0 && $urandom_range(9) < 7)
        pool[i] = base_corners[$urandom_range(base_vcount - 1)];
      else
        pool[i] = random_corner();
    end
    for (int i = 0; i < length; i++) begin
      c = pool[$urandom_range(kinds - 1)];
      if ($urandom_range(4) == 0) c[3] = random_weight();
      send_corner(make_word(derived, c, (i == length - 1) && ($urandom_range(9) != 0)));
    end
  endtask

  task automatic test_random_tables(input int count);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      len = $urandom_range(1, 12);
      if (pick < 45) begin
        send_table(1'b0, len);
      end else if (pick < 85) begin
        send_table(1'b1, len);
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_corner(make_word(1'($urandom_range(1)), random_corner(),
                                1'($urandom_range(1))));
        end
      end
      sent += len;
    end
    wait_for_results();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 68;
    test_corner_basics();
    test_weight_setting();
    test_output_hold_off();

    send_idle_pct = 38;
    recv_idle_pct = 68;
    set_weights_per_vertex(vdib_pkg::WPV_THREE);
    test_random_tables(180);
    send_idle_pct = 68;
    recv_idle_pct = 38;
    set_weights_per_vertex(vdib_pkg::WPV_FOUR);
    test_random_tables(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_weights_per_vertex(WPV_ODD_MID);
    test_random_tables(170);

    set_weights_per_vertex(vdib_pkg::WPV_THREE);

    wait_for_results();
    repeat (2100) @(negedge clk);
    if (errors == 0) begin
      $display("vertex_dedup_index_builder_test: PASS");
    end else begin
      $display("vertex_dedup_index_builder_test: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/vdib_pkg.sv
design/vdib_ram.sv
design/vdib_cmp.sv
design/vertex_dedup_index_builder.sv
tb/sv/vertex_dedup_index_builder_test.sv
